/* src/distance_to_parameter_lookup_assert.svh */
// ---------------------------------------------------------------------------
// distance_to_parameter_lookup assertion macros
// Concurrent assertion wrappers; compiled out when NO_ASSERTIONS is defined.
// ---------------------------------------------------------------------------
`ifndef DISTANCE_TO_PARAMETER_LOOKUP_ASSERT_SVH
`define DISTANCE_TO_PARAMETER_LOOKUP_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define DTPL_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("dtpl assertion failed");

`define DTPL_ASSERT_NEXT(lbl, clk, rst_n, cond, nxt) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error("dtpl assertion failed");

`else

`define DTPL_ASSERT(lbl, clk, rst_n, prop)

`define DTPL_ASSERT_NEXT(lbl, clk, rst_n, cond, nxt)

`endif

`endif

/* src/dtpl_pkg.sv */
// ---------------------------------------------------------------------------
// dtpl_pkg
// Shared widths, codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dtpl_pkg;

    localparam int DEF_MAX_ENTRIES  = 1024;
    localparam int DEF_MAX_SEGMENTS = 16;
    localparam int DEF_FRAC_BITS    = 16;

    localparam int ENTRY_INDEX_W = 10;
    localparam int ENTRY_VALUE_W = 31;
    localparam int QUERY_W       = 32;
    localparam int SEG_INDEX_W   = 4;
    localparam int SEG_FRAC_W    = 17;
    localparam int SEG_COUNT_W   = 5;
    localparam int ENTRY_COUNT_W = 11;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 24;
    localparam int M_PAD_W   = M_TDATA_W - SEG_FRAC_W - SEG_INDEX_W;

    localparam int ENTRY_INDEX_LSB = 0;
    localparam int ENTRY_VALUE_LSB = ENTRY_INDEX_LSB + ENTRY_INDEX_W;
    localparam int QUERY_LSB       = ENTRY_VALUE_LSB + ENTRY_VALUE_W;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT   = 1'b1;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [SEG_COUNT_W-1:0]   SEG_COUNT_RST   = 5'd1;
    localparam logic [ENTRY_COUNT_W-1:0] ENTRY_COUNT_RST = 11'd2;

    typedef enum logic [1:0] {
        RD_LAST  = 2'd0,
        RD_PROBE = 2'd1,
        RD_B     = 2'd2,
        RD_A     = 2'd3
    } dtpl_rd_sel_t;

    typedef enum logic [1:0] {
        RES_ZERO  = 2'd0,
        RES_FULL  = 2'd1,
        RES_ALPHA = 2'd2
    } dtpl_res_kind_t;

    typedef struct packed {
        logic           load_wr;
        logic           query_cap;
        logic           rd_en;
        dtpl_rd_sel_t   rd_sel;
        logic           srch_init;
        logic           srch_upd;
        logic           tb_cap;
        logic           div1_ld;
        logic           div_step;
        logic           pos_ld;
        logic           div2_ld;
        logic           res_ld;
        dtpl_res_kind_t res_kind;
    } dtpl_cmd_t;

    typedef struct packed {
        logic d_nonpos;
        logic last_hit;
        logic srch_empty;
        logic a_bad;
        logic div_last;
    } dtpl_status_t;

endpackage

`default_nettype wire

/* src/dtpl_cfg.sv */
// ---------------------------------------------------------------------------
// dtpl_cfg
// APB register file: segment_count and entry_count.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dtpl_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [dtpl_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [dtpl_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [dtpl_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                 pready,
    output logic [dtpl_pkg::SEG_COUNT_W-1:0]     segment_count,
    output logic [dtpl_pkg::ENTRY_COUNT_W-1:0]   entry_count
);
    import dtpl_pkg::*;

    logic [SEG_COUNT_W-1:0]   segment_count_reg, segment_count_next;
    logic [ENTRY_COUNT_W-1:0] entry_count_reg, entry_count_next;
    logic [CFG_IDX_W-1:0]     reg_idx;
    logic                     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        segment_count_next = segment_count_reg;
        entry_count_next   = entry_count_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_SEGMENT_COUNT: segment_count_next = pwdata[SEG_COUNT_W-1:0];
                REG_ENTRY_COUNT:   entry_count_next   = pwdata[ENTRY_COUNT_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_SEGMENT_COUNT: prdata = CFG_DATA_W'(segment_count_reg);
            REG_ENTRY_COUNT:   prdata = CFG_DATA_W'(entry_count_reg);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            segment_count_reg <= SEG_COUNT_RST;
            entry_count_reg   <= ENTRY_COUNT_RST;
        end
        else
        begin
            segment_count_reg <= segment_count_next;
            entry_count_reg   <= entry_count_next;
        end
    end

    assign segment_count = segment_count_reg;
    assign entry_count   = entry_count_reg;

endmodule

`default_nettype wire

/* src/dtpl_ctrl.sv */
// ---------------------------------------------------------------------------
// dtpl_ctrl
// Sequencer: load/query dispatch, search loop, two divisions, result handoff.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "distance_to_parameter_lookup_assert.svh"

module dtpl_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic                    s_tuser,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    input  dtpl_pkg::dtpl_status_t  st,
    output dtpl_pkg::dtpl_cmd_t     cmd
);
    import dtpl_pkg::*;

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b0000_0000_0001,
        ST_CHECK  = 12'b0000_0000_0010,
        ST_LAST   = 12'b0000_0000_0100,
        ST_SEARCH = 12'b0000_0000_1000,
        ST_PROBE  = 12'b0000_0001_0000,
        ST_TB     = 12'b0000_0010_0000,
        ST_TA     = 12'b0000_0100_0000,
        ST_DIV1   = 12'b0000_1000_0000,
        ST_POS    = 12'b0001_0000_0000,
        ST_MUL    = 12'b0010_0000_0000,
        ST_DIV2   = 12'b0100_0000_0000,
        ST_OUT    = 12'b1000_0000_0000
    } dtpl_state_t;

    dtpl_state_t    state_reg, state_next;
    dtpl_res_kind_t res_kind_reg, res_kind_next;
    logic           m_tvalid_reg, m_tvalid_next;
    logic           out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb
    begin
        state_next    = state_reg;
        res_kind_next = res_kind_reg;
        cmd           = '0;
        cmd.rd_sel    = RD_LAST;
        cmd.res_kind  = res_kind_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser == CMD_LOAD)
                    begin
                        cmd.load_wr = 1'b1;
                    end
                    else
                    begin
                        cmd.query_cap = 1'b1;
                        state_next    = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (st.d_nonpos)
                begin
                    res_kind_next = RES_ZERO;
                    state_next    = ST_OUT;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_LAST;
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                if (st.last_hit)
                begin
                    res_kind_next = RES_FULL;
                    state_next    = ST_OUT;
                end
                else
                begin
                    cmd.srch_init = 1'b1;
                    state_next    = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (st.srch_empty)
                begin
                    if (st.a_bad)
                    begin
                        res_kind_next = RES_ZERO;
                        state_next    = ST_OUT;
                    end
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_B;
                        state_next = ST_TB;
                    end
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_PROBE;
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                cmd.srch_upd = 1'b1;
                state_next   = ST_SEARCH;
            end
            ST_TB:
            begin
                cmd.tb_cap = 1'b1;
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_A;
                state_next = ST_TA;
            end
            ST_TA:
            begin
                cmd.div1_ld = 1'b1;
                state_next  = ST_DIV1;
            end
            ST_DIV1:
            begin
                cmd.div_step = 1'b1;
                if (st.div_last)
                begin
                    state_next = ST_POS;
                end
            end
            ST_POS:
            begin
                cmd.pos_ld = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.div2_ld = 1'b1;
                state_next  = ST_DIV2;
            end
            ST_DIV2:
            begin
                cmd.div_step = 1'b1;
                if (st.div_last)
                begin
                    res_kind_next = RES_ALPHA;
                    state_next    = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.res_ld = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.res_ld)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            res_kind_reg <= RES_ZERO;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            res_kind_reg <= res_kind_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    `DTPL_ASSERT_NEXT(a_load_stays_idle, clk, rst_n, s_tvalid && s_tready && s_tuser == CMD_LOAD, s_tready)
    `DTPL_ASSERT_NEXT(a_query_busy, clk, rst_n, s_tvalid && s_tready && s_tuser == CMD_QUERY, !s_tready)
    `DTPL_ASSERT(a_no_overwrite, clk, rst_n, cmd.res_ld |-> (!m_tvalid_reg || m_tready))

endmodule

`default_nettype wire

/* src/dtpl_dp.sv */
// ---------------------------------------------------------------------------
// dtpl_dp
// Distance table memory, search registers, shared shift-subtract divider,
// position multiplier and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "distance_to_parameter_lookup_assert.svh"

module dtpl_dp #(
    parameter int MAX_ENTRIES  = dtpl_pkg::DEF_MAX_ENTRIES,
    parameter int MAX_SEGMENTS = dtpl_pkg::DEF_MAX_SEGMENTS,
    parameter int FRAC_BITS    = dtpl_pkg::DEF_FRAC_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [dtpl_pkg::SEG_COUNT_W-1:0]     segment_count,
    input  logic [dtpl_pkg::ENTRY_COUNT_W-1:0]   entry_count,
    input  logic [dtpl_pkg::ENTRY_INDEX_W-1:0]   entry_index,
    input  logic [dtpl_pkg::ENTRY_VALUE_W-1:0]   entry_value,
    input  logic signed [dtpl_pkg::QUERY_W-1:0]  query_distance,
    input  dtpl_pkg::dtpl_cmd_t                  cmd,
    output dtpl_pkg::dtpl_status_t               st,
    output logic [dtpl_pkg::SEG_INDEX_W-1:0]     segment_index,
    output logic [dtpl_pkg::SEG_FRAC_W-1:0]      segment_fraction
);
    import dtpl_pkg::*;

    localparam int AW  = $clog2(MAX_ENTRIES);
    localparam int NW  = $clog2(MAX_ENTRIES + 1);
    localparam int SW  = $clog2(MAX_SEGMENTS + 1);
    localparam int TW  = ENTRY_VALUE_W;
    localparam int PSW = NW + FRAC_BITS;
    localparam int PW  = PSW + SW;
    localparam int QW  = SW + FRAC_BITS + 1;
    localparam int RW  = TW + 1;
    localparam int CW  = $clog2(QW + 1);

    logic [TW-1:0] mem [MAX_ENTRIES];
    logic [TW-1:0] rdata_reg;

    logic [QUERY_W-1:0] d_reg, d_next;
    logic [SW-1:0]      s_reg, s_next;
    logic [NW-1:0]      n_reg, n_next;
    logic [NW-1:0]      first_reg, first_next;
    logic [NW-1:0]      count_reg, count_next;
    logic [TW-1:0]      tb_reg, tb_next;
    logic [RW-1:0]      r_reg, r_next;
    logic [QW-1:0]      feed_reg, feed_next;
    logic [TW-1:0]      dvsr_reg, dvsr_next;
    logic [QW-1:0]      quot_reg, quot_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               den_zero_reg, den_zero_next;
    logic [PSW-1:0]     pos_reg, pos_next;
    logic [SEG_INDEX_W-1:0] seg_out_reg, seg_out_next;
    logic [SEG_FRAC_W-1:0]  frac_out_reg, frac_out_next;

    logic [31:0]        s_wide, n_wide, s_clamp, n_clamp;
    logic [NW-1:0]      probe, rd_idx, b_idx, nm1;
    logic [SW-1:0]      sm1;
    logic               load_ok, probe_lt;
    logic [TW-1:0]      num, den;
    logic [FRAC_BITS:0] local_q, one_q;
    logic [PW-1:0]      prod_w;
    logic [RW-1:0]      r_shift, r_sub;
    logic               r_ge;

    // effective register values
    assign s_wide  = 32'(segment_count);
    assign n_wide  = 32'(entry_count);
    assign s_clamp = (s_wide < 32'd1) ? 32'd1 :
                     (s_wide > 32'(MAX_SEGMENTS)) ? 32'(MAX_SEGMENTS) : s_wide;
    assign n_clamp = (n_wide < 32'd2) ? 32'd2 :
                     (n_wide > 32'(MAX_ENTRIES)) ? 32'(MAX_ENTRIES) : n_wide;

    assign load_ok = 32'(entry_index) < 32'(MAX_ENTRIES);
    assign probe   = first_reg + (count_reg >> 1);
    assign b_idx   = first_reg - NW'(1);
    assign nm1     = n_reg - NW'(1);
    assign sm1     = s_reg - SW'(1);

    always_comb
    begin
        case (cmd.rd_sel)
            RD_LAST:  rd_idx = nm1;
            RD_PROBE: rd_idx = probe;
            RD_B:     rd_idx = b_idx;
            RD_A:     rd_idx = first_reg;
            default:  rd_idx = first_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_wr && load_ok)
        begin
            mem[AW'(entry_index)] <= entry_value;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[rd_idx[AW-1:0]];
        end
    end

    assign probe_lt = {1'b0, rdata_reg} < d_reg;
    assign num      = d_reg[TW-1:0] - tb_reg;
    assign den      = rdata_reg - tb_reg;
    assign local_q  = den_zero_reg ? '0 : quot_reg[FRAC_BITS:0];
    assign one_q    = {1'b1, {FRAC_BITS{1'b0}}};
    assign prod_w   = {{SW{1'b0}}, pos_reg} * {{PSW{1'b0}}, s_reg};

    // one restoring division step
    assign r_shift = {r_reg[RW-2:0], feed_reg[QW-1]};
    assign r_ge    = r_shift >= {1'b0, dvsr_reg};
    assign r_sub   = r_shift - {1'b0, dvsr_reg};

    always_comb
    begin
        d_next        = d_reg;
        s_next        = s_reg;
        n_next        = n_reg;
        first_next    = first_reg;
        count_next    = count_reg;
        tb_next       = tb_reg;
        r_next        = r_reg;
        feed_next     = feed_reg;
        dvsr_next     = dvsr_reg;
        quot_next     = quot_reg;
        cnt_next      = cnt_reg;
        den_zero_next = den_zero_reg;
        pos_next      = pos_reg;
        seg_out_next  = seg_out_reg;
        frac_out_next = frac_out_reg;

        if (cmd.query_cap)
        begin
            d_next = query_distance;
            s_next = SW'(s_clamp);
            n_next = NW'(n_clamp);
        end

        if (cmd.srch_init)
        begin
            first_next = '0;
            count_next = n_reg;
        end

        if (cmd.srch_upd)
        begin
            if (probe_lt)
            begin
                first_next = probe + NW'(1);
                count_next = count_reg - (count_reg >> 1) - NW'(1);
            end
            else
            begin
                count_next = count_reg >> 1;
            end
        end

        if (cmd.tb_cap)
        begin
            tb_next = rdata_reg;
        end

        if (cmd.div1_ld)
        begin
            r_next        = RW'(num >> 1);
            feed_next     = {num[0], {(QW-1){1'b0}}};
            dvsr_next     = den;
            quot_next     = '0;
            cnt_next      = CW'(FRAC_BITS + 1);
            den_zero_next = (den == '0);
        end

        if (cmd.div_step)
        begin
            r_next    = r_ge ? r_sub : r_shift;
            feed_next = feed_reg << 1;
            quot_next = {quot_reg[QW-2:0], r_ge};
            cnt_next  = cnt_reg - CW'(1);
        end

        if (cmd.pos_ld)
        begin
            pos_next = {b_idx, {FRAC_BITS{1'b0}}} + PSW'(local_q);
        end

        if (cmd.div2_ld)
        begin
            r_next    = RW'(prod_w[PW-1:QW]);
            feed_next = prod_w[QW-1:0];
            dvsr_next = TW'(nm1);
            quot_next = '0;
            cnt_next  = CW'(QW);
        end

        if (cmd.res_ld)
        begin
            case (cmd.res_kind)
                RES_ZERO:
                begin
                    seg_out_next  = '0;
                    frac_out_next = '0;
                end
                RES_FULL:
                begin
                    seg_out_next  = SEG_INDEX_W'(sm1);
                    frac_out_next = SEG_FRAC_W'(one_q);
                end
                RES_ALPHA:
                begin
                    seg_out_next  = SEG_INDEX_W'(quot_reg[QW-1:FRAC_BITS]);
                    frac_out_next = SEG_FRAC_W'(quot_reg[FRAC_BITS-1:0]);
                end
                default:
                begin
                    seg_out_next  = '0;
                    frac_out_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg        <= d_next;
        s_reg        <= s_next;
        n_reg        <= n_next;
        first_reg    <= first_next;
        count_reg    <= count_next;
        tb_reg       <= tb_next;
        r_reg        <= r_next;
        feed_reg     <= feed_next;
        dvsr_reg     <= dvsr_next;
        quot_reg     <= quot_next;
        cnt_reg      <= cnt_next;
        den_zero_reg <= den_zero_next;
        pos_reg      <= pos_next;
        seg_out_reg  <= seg_out_next;
        frac_out_reg <= frac_out_next;
    end

    assign st.d_nonpos   = (d_reg == '0) || d_reg[QUERY_W-1];
    assign st.last_hit   = d_reg >= {1'b0, rdata_reg};
    assign st.srch_empty = (count_reg == '0);
    assign st.a_bad      = (first_reg == '0) || (first_reg >= n_reg);
    assign st.div_last   = (cnt_reg == CW'(1));

    assign segment_index    = seg_out_reg;
    assign segment_fraction = frac_out_reg;

    `DTPL_ASSERT_NEXT(a_search_shrinks, clk, rst_n, cmd.srch_upd, count_reg < $past(count_reg))
    `DTPL_ASSERT(a_div_count_live, clk, rst_n, cmd.div_step |-> (cnt_reg != '0))

endmodule

`default_nettype wire

/* src/distance_to_parameter_lookup.sv */
// ---------------------------------------------------------------------------
// distance_to_parameter_lookup
// Maps a Q16.16 path distance to a segment index and fraction through a
// loaded table of monotone cumulative distances.
// ---------------------------------------------------------------------------
//  channel  dir  words                       fields (low bit up)
//  s_axis   in   load or query               tuser: command
//                                            tdata: entry_index, entry_value,
//                                                   query_distance
//  m_axis   out  one word per query          tdata: segment_index,
//                                                   segment_fraction
//  apb      in   segment_count @0, entry_count @4
//
//  Load: written in the cycle it is taken. Query at or below zero: answered
//  without a table read; at or past the last entry: answered after reading
//  it; otherwise k search probes (about log2 of entry_count), then two
//  divisions. Query time is set by the single registered table read port (a
//  read, then a compare, per probe) and the 1-bit-per-cycle divider.
//  A finished word waits in the output register; loads and the next query
//  are taken meanwhile. Reset clears control only; table undefined until
//  written.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module distance_to_parameter_lookup #(
    parameter int MAX_ENTRIES  = dtpl_pkg::DEF_MAX_ENTRIES,
    parameter int MAX_SEGMENTS = dtpl_pkg::DEF_MAX_SEGMENTS,
    parameter int FRAC_BITS    = dtpl_pkg::DEF_FRAC_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [72:41] query_distance, [40:10] entry_value, [9:0] entry_index
    input  logic [dtpl_pkg::S_TDATA_W-1:0]    s_tdata,
    // [0] command
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [20:4] segment_fraction, [3:0] segment_index
    output logic [dtpl_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dtpl_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [dtpl_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [dtpl_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import dtpl_pkg::*;

    logic [SEG_COUNT_W-1:0]    segment_count;
    logic [ENTRY_COUNT_W-1:0]  entry_count;
    logic [ENTRY_INDEX_W-1:0]  entry_index;
    logic [ENTRY_VALUE_W-1:0]  entry_value;
    logic signed [QUERY_W-1:0] query_distance;
    logic [SEG_INDEX_W-1:0]    segment_index;
    logic [SEG_FRAC_W-1:0]     segment_fraction;
    dtpl_cmd_t                 cmd;
    dtpl_status_t              st;

    assign entry_index    = s_tdata[ENTRY_INDEX_LSB +: ENTRY_INDEX_W];
    assign entry_value    = s_tdata[ENTRY_VALUE_LSB +: ENTRY_VALUE_W];
    assign query_distance = s_tdata[QUERY_LSB +: QUERY_W];
    assign m_tdata        = {{M_PAD_W{1'b0}}, segment_fraction, segment_index};

    dtpl_cfg u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .segment_count (segment_count),
        .entry_count   (entry_count)
    );

    dtpl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .st       (st),
        .cmd      (cmd)
    );

    dtpl_dp #(
        .MAX_ENTRIES  (MAX_ENTRIES),
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .FRAC_BITS    (FRAC_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .segment_count    (segment_count),
        .entry_count      (entry_count),
        .entry_index      (entry_index),
        .entry_value      (entry_value),
        .query_distance   (query_distance),
        .cmd              (cmd),
        .st               (st),
        .segment_index    (segment_index),
        .segment_fraction (segment_fraction)
    );

endmodule

`default_nettype wire
